// ----- hdl/tam_pkg.sv -----
package tam_pkg;

  localparam int TEMP_W     = 12;
  localparam int CFG_TEMP_W = 12;
  localparam int CNT_OUT_W  = 16;
  localparam int TOTAL_W    = 28;
  localparam int DUR_W      = 24;
  localparam int BYTE_W     = 8;
  localparam int DIFF_W     = TEMP_W + 1;

  localparam int DEF_COUNT_WIDTH = 16;

  localparam logic signed [DIFF_W-1:0] STEP_ONE = DIFF_W'(20);
  localparam logic signed [DIFF_W-1:0] STEP_TWO = DIFF_W'(50);

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

  localparam logic [1:0] LVL_NORMAL = 2'd0;
  localparam logic [1:0] LVL_ONE    = 2'd1;
  localparam logic [1:0] LVL_TWO    = 2'd2;
  localparam logic [1:0] LVL_THREE  = 2'd3;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_LOW_THRESHOLD  = 2'd0,
    REG_HIGH_THRESHOLD = 2'd1,
    REG_INTERVAL       = 2'd2,
    REG_ALERTS_NEEDED  = 2'd3
  } tam_reg_t;

  typedef struct packed {
    logic                     kind;
    logic signed [TEMP_W-1:0] temperature;
  } tam_in_t;

  typedef struct packed {
    logic [1:0]                level;
    logic                      run_alarm;
    logic [CNT_OUT_W-1:0]      run_length;
    logic [CNT_OUT_W-1:0]      sample_count;
    logic [CNT_OUT_W-1:0]      level_one_count;
    logic [CNT_OUT_W-1:0]      level_two_count;
    logic [CNT_OUT_W-1:0]      level_three_count;
    logic signed [TEMP_W-1:0]  lowest;
    logic signed [TEMP_W-1:0]  highest;
    logic signed [TOTAL_W-1:0] total;
    logic [DUR_W-1:0]          alert_minutes;
  } tam_out_t;

  typedef struct packed {
    logic signed [CFG_TEMP_W-1:0] low_threshold;
    logic signed [CFG_TEMP_W-1:0] high_threshold;
    logic [BYTE_W-1:0]            interval_minutes;
    logic [BYTE_W-1:0]            alerts_needed;
  } tam_cfg_t;

  // classified item between front and back
  typedef struct packed {
    logic                     kind;
    logic signed [TEMP_W-1:0] temperature;
    logic [1:0]               level;
  } tam_cls_t;

  function automatic logic [1:0] tam_grade(input logic signed [DIFF_W-1:0] diff);
    logic [1:0] lvl;
    if (diff <= STEP_ONE) begin
      lvl = LVL_ONE;
    end else if (diff <= STEP_TWO) begin
      lvl = LVL_TWO;
    end else begin
      lvl = LVL_THREE;
    end
    return lvl;
  endfunction

endpackage

// ----- hdl/tam_front.sv -----
module tam_front import tam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tam_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  tam_in_t  in_data,
  output logic     cls_valid,
  input  logic     cls_ready,
  output tam_cls_t cls_data
);

  logic                     front_valid_r;
  logic                     front_valid_nxt;
  tam_cls_t                 front_item_r;
  tam_cls_t                 front_item_nxt;
  logic signed [DIFF_W-1:0] diff_lo;
  logic signed [DIFF_W-1:0] diff_hi;
  logic                     below;
  logic                     above;
  logic [1:0]               lvl;
  logic                     load;

  always_comb begin
    diff_lo = DIFF_W'(cfg.low_threshold) - DIFF_W'(in_data.temperature);
    diff_hi = DIFF_W'(in_data.temperature) - DIFF_W'(cfg.high_threshold);
    below   = in_data.temperature < cfg.low_threshold;
    above   = in_data.temperature > cfg.high_threshold;
    // low threshold is checked first when the two are crossed
    priority if (in_data.kind == KIND_CLEAR) begin
      lvl = LVL_NORMAL;
    end else if (below) begin
      lvl = tam_grade(diff_lo);
    end else if (above) begin
      lvl = tam_grade(diff_hi);
    end else begin
      lvl = LVL_NORMAL;
    end
  end

  assign in_stall = front_valid_r & ~cls_ready;
  assign load     = in_valid & ~in_stall;

  always_comb begin
    front_valid_nxt = front_valid_r;
    front_item_nxt  = front_item_r;
    if (load) begin
      front_valid_nxt          = 1'b1;
      front_item_nxt.kind        = in_data.kind;
      front_item_nxt.temperature = in_data.temperature;
      front_item_nxt.level       = lvl;
    end else if (cls_ready) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
    front_item_r <= front_item_nxt;
  end

  assign cls_valid = front_valid_r;
  assign cls_data  = front_item_r;

endmodule

// ----- hdl/tam_queue.sv -----
module tam_queue import tam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  tam_cls_t wr_data,
  output logic     rd_valid,
  input  logic     rd_take,
  output tam_cls_t rd_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tam_cls_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = fill_r != CNT_W'(DEPTH);
  assign rd_valid = fill_r != '0;
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_take & rd_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- hdl/tam_back.sv -----
module tam_back import tam_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  tam_cfg_t cfg,
  input  logic     cls_valid,
  output logic     cls_take,
  input  tam_cls_t cls_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tam_out_t out_data
);

  localparam int CMP_W = (COUNT_WIDTH > BYTE_W) ? COUNT_WIDTH : BYTE_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic signed [TOTAL_W-1:0] TOT_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOT_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                level_r, level_nxt;
  logic [COUNT_WIDTH-1:0]    run_r, run_nxt;
  logic [COUNT_WIDTH-1:0]    seen_r, seen_nxt;
  logic [COUNT_WIDTH-1:0]    lvl1_r, lvl1_nxt;
  logic [COUNT_WIDTH-1:0]    lvl2_r, lvl2_nxt;
  logic [COUNT_WIDTH-1:0]    lvl3_r, lvl3_nxt;
  logic signed [TEMP_W-1:0]  min_r, min_nxt;
  logic signed [TEMP_W-1:0]  max_r, max_nxt;
  logic signed [TOTAL_W-1:0] sum_r, sum_nxt;
  logic [DUR_W-1:0]          dur_r, dur_nxt;
  logic signed [TOTAL_W:0]   sum_wide;
  logic [DUR_W:0]            dur_wide;
  logic [BYTE_W-1:0]         need;
  logic                      run_hit;
  logic signed [TEMP_W-1:0]  t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

  assign need     = (cfg.alerts_needed == '0) ? BYTE_W'(1) : cfg.alerts_needed;
  assign cls_take = cls_valid & (~out_valid_r | ~out_stall);
  assign t        = cls_data.temperature;

  always_comb begin
    sum_wide = (TOTAL_W + 1)'(sum_r) + (TOTAL_W + 1)'(t);
    dur_wide = (DUR_W + 1)'(dur_r) + (DUR_W + 1)'(cfg.interval_minutes);
  end

  always_comb begin
    out_valid_nxt = cls_take | (out_valid_r & out_stall);
    level_nxt = level_r;
    run_nxt   = run_r;
    seen_nxt  = seen_r;
    lvl1_nxt  = lvl1_r;
    lvl2_nxt  = lvl2_r;
    lvl3_nxt  = lvl3_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    dur_nxt   = dur_r;
    run_hit   = 1'b0;
    if (cls_take) begin
      level_nxt = cls_data.level;
      if (cls_data.kind == KIND_CLEAR) begin
        run_nxt  = '0;
        seen_nxt = '0;
        lvl1_nxt = '0;
        lvl2_nxt = '0;
        lvl3_nxt = '0;
        min_nxt  = TEMP_MAX;
        max_nxt  = TEMP_MIN;
        sum_nxt  = '0;
        dur_nxt  = '0;
      end else begin
        // total freezes once the sample count has saturated
        if (seen_r != CNT_MAX) begin
          if (sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1]) begin
            sum_nxt = sum_wide[TOTAL_W] ? TOT_MIN : TOT_MAX;
          end else begin
            sum_nxt = sum_wide[TOTAL_W-1:0];
          end
        end
        seen_nxt = sat_inc(seen_r);
        if (t < min_r) begin
          min_nxt = t;
        end
        if (t > max_r) begin
          max_nxt = t;
        end
        unique case (cls_data.level)
          LVL_ONE:   lvl1_nxt = sat_inc(lvl1_r);
          LVL_TWO:   lvl2_nxt = sat_inc(lvl2_r);
          LVL_THREE: lvl3_nxt = sat_inc(lvl3_r);
          default:   ;
        endcase
        if (cls_data.level != LVL_NORMAL) begin
          run_nxt = sat_inc(run_r);
          run_hit = CMP_W'(run_nxt) >= CMP_W'(need);
          if (run_hit) begin
            dur_nxt = dur_wide[DUR_W] ? DUR_MAX : dur_wide[DUR_W-1:0];
          end
        end else begin
          run_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      level_r     <= LVL_NORMAL;
      run_r       <= '0;
      seen_r      <= '0;
      lvl1_r      <= '0;
      lvl2_r      <= '0;
      lvl3_r      <= '0;
      min_r       <= TEMP_MAX;
      max_r       <= TEMP_MIN;
      sum_r       <= '0;
      dur_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      level_r     <= level_nxt;
      run_r       <= run_nxt;
      seen_r      <= seen_nxt;
      lvl1_r      <= lvl1_nxt;
      lvl2_r      <= lvl2_nxt;
      lvl3_r      <= lvl3_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      dur_r       <= dur_nxt;
    end
  end

  // statistics registers double as the output register: they only move on a take
  always_comb begin
    out_data.level             = level_r;
    out_data.run_alarm         = CMP_W'(run_r) >= CMP_W'(need);
    out_data.run_length        = CNT_OUT_W'(run_r);
    out_data.sample_count      = CNT_OUT_W'(seen_r);
    out_data.level_one_count   = CNT_OUT_W'(lvl1_r);
    out_data.level_two_count   = CNT_OUT_W'(lvl2_r);
    out_data.level_three_count = CNT_OUT_W'(lvl3_r);
    out_data.lowest            = min_r;
    out_data.highest           = max_r;
    out_data.total             = sum_r;
    out_data.alert_minutes     = dur_r;
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/temperature_alert_monitor_top.sv -----
// temperature alert monitor
// in channel: in_valid / in_stall / in_data carries one transaction per sample,
//   kind 0 is a temperature in signed tenths of a degree, kind 1 clears all statistics
// out channel: out_valid / out_stall / out_data carries one report per input
//   transaction: alert level of the sample plus the full statistics snapshot
// cfg port: APB-style writes to thresholds, interval and alerts_needed, at
//   byte addresses 0, 4, 8, 12; pready is always high, reads return the value
// datapath: the accept edge loads the front register; from there the
//   transaction passes through the queue into the statistics register;
//   throughput one transaction per cycle while out_stall is low, set by the
//   statistics update in the back end
// reset (rst_n low, synchronous): registers return to 15.0 / 30.0 degrees,
//   5 minutes and 3 samples, all statistics cleared, nothing in flight
// stall: a stalled result holds; the two-entry queue and the front register
//   keep absorbing input until both are full, then in_stall rises
module temperature_alert_monitor_top import tam_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tam_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tam_out_t              out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  tam_cfg_t cfg_r, cfg_nxt;
  tam_reg_t reg_sel;
  logic     cfg_wr;

  logic     cls_valid, cls_ready;
  tam_cls_t cls_data;
  logic     q_valid, q_take;
  tam_cls_t q_data;

  // ---------------- configuration registers
  assign cfg_pready = 1'b1;
  assign reg_sel    = tam_reg_t'(cfg_paddr[APB_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_LOW_THRESHOLD:  cfg_nxt.low_threshold    = cfg_pwdata[CFG_TEMP_W-1:0];
        REG_HIGH_THRESHOLD: cfg_nxt.high_threshold   = cfg_pwdata[CFG_TEMP_W-1:0];
        REG_INTERVAL:       cfg_nxt.interval_minutes = cfg_pwdata[BYTE_W-1:0];
        REG_ALERTS_NEEDED:  cfg_nxt.alerts_needed    = cfg_pwdata[BYTE_W-1:0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LOW_THRESHOLD:  cfg_prdata = APB_DATA_W'(cfg_r.low_threshold);
      REG_HIGH_THRESHOLD: cfg_prdata = APB_DATA_W'(cfg_r.high_threshold);
      REG_INTERVAL:       cfg_prdata = APB_DATA_W'(cfg_r.interval_minutes);
      REG_ALERTS_NEEDED:  cfg_prdata = APB_DATA_W'(cfg_r.alerts_needed);
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_threshold    <= CFG_TEMP_W'(150);
      cfg_r.high_threshold   <= CFG_TEMP_W'(300);
      cfg_r.interval_minutes <= BYTE_W'(5);
      cfg_r.alerts_needed    <= BYTE_W'(3);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- front: accept and classify
  tam_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_data  (cls_data)
  );

  // ---------------- queue decoupling front and back
  tam_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cls_valid),
    .wr_ready (cls_ready),
    .wr_data  (cls_data),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_data  (q_data)
  );

  // ---------------- back: statistics update and report
  tam_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cls_valid (q_valid),
    .cls_take  (q_take),
    .cls_data  (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sim/tam_report_checker.sv -----
module tam_report_checker
  import tam_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  tam_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  tam_out_t              out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output int                    mismatches,
  output int                    reports_owed
);

  localparam int CNT_MAX     = (1 << DEF_COUNT_WIDTH) - 1;
  localparam int MINUTES_MAX = (1 << DUR_W) - 1;
  localparam int SUM_MAX     = (1 << (TOTAL_W - 1)) - 1;
  localparam int SUM_MIN     = -(1 << (TOTAL_W - 1));

  localparam int RST_LOW      = 150;
  localparam int RST_HIGH     = 300;
  localparam int RST_INTERVAL = 5;
  localparam int RST_NEEDED   = 3;

  // register copy
  int lo_limit;
  int hi_limit;
  int minutes_per_sample;
  int run_needed;

  // statistics copy
  int run_len;
  int seen;
  int tally [3];
  int coldest;
  int hottest;
  int temp_sum;
  int alert_mins;

  tam_out_t owed_reports [$];

  function automatic logic [1:0] band_of(input int gap);
    if (gap <= int'(STEP_ONE)) begin
      return LVL_ONE;
    end
    if (gap <= int'(STEP_TWO)) begin
      return LVL_TWO;
    end
    return LVL_THREE;
  endfunction

  task automatic wipe_stats();
    run_len    = 0;
    seen       = 0;
    tally[0]   = 0;
    tally[1]   = 0;
    tally[2]   = 0;
    coldest    = int'(TEMP_MAX);
    hottest    = int'(TEMP_MIN);
    temp_sum   = 0;
    alert_mins = 0;
  endtask

  // advances the statistics by one transaction and builds its report
  task automatic next_report(input tam_in_t item, output tam_out_t rpt);
    int         t;
    int         need;
    logic [1:0] lvl;
    need = (run_needed == 0) ? 1 : run_needed;
    lvl  = LVL_NORMAL;
    if (item.kind == KIND_CLEAR) begin
      wipe_stats();
    end else begin
      t = int'($signed(item.temperature));
      // below low is judged first, even with crossed thresholds
      if (t < lo_limit) begin
        lvl = band_of(lo_limit - t);
      end else if (t > hi_limit) begin
        lvl = band_of(t - hi_limit);
      end
      // total freezes once the sample count is saturated
      if (seen < CNT_MAX) begin
        temp_sum = temp_sum + t;
        if (temp_sum > SUM_MAX) begin
          temp_sum = SUM_MAX;
        end
        if (temp_sum < SUM_MIN) begin
          temp_sum = SUM_MIN;
        end
        seen++;
      end
      if (t < coldest) begin
        coldest = t;
      end
      if (t > hottest) begin
        hottest = t;
      end
      if (lvl != LVL_NORMAL) begin
        if (tally[lvl - 1] < CNT_MAX) begin
          tally[lvl - 1]++;
        end
        if (run_len < CNT_MAX) begin
          run_len++;
        end
        if (run_len >= need) begin
          alert_mins = (alert_mins + minutes_per_sample > MINUTES_MAX) ?
                       MINUTES_MAX : alert_mins + minutes_per_sample;
        end
      end else begin
        run_len = 0;
      end
    end
    rpt.level             = lvl;
    rpt.run_alarm         = (run_len >= need);
    rpt.run_length        = CNT_OUT_W'(run_len);
    rpt.sample_count      = CNT_OUT_W'(seen);
    rpt.level_one_count   = CNT_OUT_W'(tally[0]);
    rpt.level_two_count   = CNT_OUT_W'(tally[1]);
    rpt.level_three_count = CNT_OUT_W'(tally[2]);
    rpt.lowest            = TEMP_W'(coldest);
    rpt.highest           = TEMP_W'(hottest);
    rpt.total             = TOTAL_W'(temp_sum);
    rpt.alert_minutes     = DUR_W'(alert_mins);
  endtask

  task automatic match_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    tam_out_t want;
    if (!rst_n) begin
      lo_limit           = RST_LOW;
      hi_limit           = RST_HIGH;
      minutes_per_sample = RST_INTERVAL;
      run_needed         = RST_NEEDED;
      wipe_stats();
      owed_reports.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        unique case (tam_reg_t'(cfg_paddr[APB_ADDR_W-1:2]))
          REG_LOW_THRESHOLD:  lo_limit = int'($signed(cfg_pwdata[CFG_TEMP_W-1:0]));
          REG_HIGH_THRESHOLD: hi_limit = int'($signed(cfg_pwdata[CFG_TEMP_W-1:0]));
          REG_INTERVAL:       minutes_per_sample = int'(cfg_pwdata[BYTE_W-1:0]);
          REG_ALERTS_NEEDED:  run_needed = int'(cfg_pwdata[BYTE_W-1:0]);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed_reports.size() == 0) begin
          mismatches++;
          $display("%0t: report expected none actual %h", $time, out_data);
        end else begin
          want = owed_reports.pop_front();
          match_field("level", want.level, out_data.level);
          match_field("run_alarm", want.run_alarm, out_data.run_alarm);
          match_field("run_length", want.run_length, out_data.run_length);
          match_field("sample_count", want.sample_count, out_data.sample_count);
          match_field("level_one_count", want.level_one_count,
                      out_data.level_one_count);
          match_field("level_two_count", want.level_two_count,
                      out_data.level_two_count);
          match_field("level_three_count", want.level_three_count,
                      out_data.level_three_count);
          match_field("lowest", want.lowest, out_data.lowest);
          match_field("highest", want.highest, out_data.highest);
          match_field("total", want.total, out_data.total);
          match_field("alert_minutes", want.alert_minutes, out_data.alert_minutes);
        end
      end
      if (in_valid && !in_stall) begin
        next_report(in_data, want);
        owed_reports.push_back(want);
      end
    end
    reports_owed <= owed_reports.size();
  end

endmodule

// ----- sim/tb.sv -----
module tb;
  import tam_pkg::*;

  // cycles without any transaction before the run is declared hung
  localparam int QUIET_LIMIT  = 2000;
  // settle time after the last report
  localparam int DRAIN_CYCLES = 8;
  // long all-alert stream that keeps the run and the minutes growing
  localparam int ALERT_ITEMS  = 80;

  // how a random sample is aimed relative to the thresholds
  typedef enum int {
    AIM_ANY,
    AIM_BELOW,
    AIM_ABOVE,
    AIM_INSIDE
  } aim_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  tam_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  tam_out_t              out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatches;
  int reports_owed;

  // idling pressure in percent per decision, changed per episode
  int send_gap_pct;
  int stall_pct;
  int stall_left;
  int quiet_cycles;

  // thresholds as last programmed, used to aim samples at the edges
  int lo_aim = 150;
  int hi_aim = 300;

  temperature_alert_monitor_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // watches both channels and the register port, predicts every report
  tam_report_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .mismatches   (mismatches),
    .reports_owed (reports_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver back-pressure: stall bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // hang detection: any accepted transaction or register access restarts it
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int any_temp();
    return int'($signed(TEMP_W'($urandom)));
  endfunction

  // sample near a threshold edge, inside the band, or anywhere
  function automatic int aimed_temp(input aim_t aim);
    int v;
    unique case (aim)
      AIM_BELOW: v = lo_aim - int'($urandom_range(0, 70));
      AIM_ABOVE: v = hi_aim + int'($urandom_range(0, 70));
      AIM_INSIDE: begin
        if (hi_aim >= lo_aim) begin
          v = lo_aim + int'($urandom_range(0, hi_aim - lo_aim));
        end else begin
          v = hi_aim + int'($urandom_range(0, lo_aim - hi_aim));
        end
      end
      default: v = any_temp();
    endcase
    // aimed past the representable range: fall back to anything
    if (v < int'(TEMP_MIN) || v > int'(TEMP_MAX)) begin
      v = any_temp();
    end
    return v;
  endfunction

  // one input transaction, with an optional idle burst in front of it
  task automatic send_item(input logic kind, input int temp);
    tam_in_t item;
    item.kind        = kind;
    item.temperature = TEMP_W'(temp);
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // setup then access; psel stays high between back-to-back writes
  task automatic cfg_write(input tam_reg_t idx, input int value);
    logic [APB_DATA_W-1:0] keep;
    keep = (idx == REG_LOW_THRESHOLD || idx == REG_HIGH_THRESHOLD) ?
           APB_DATA_W'((1 << CFG_TEMP_W) - 1) : APB_DATA_W'((1 << BYTE_W) - 1);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_ADDR_W'(4 * int'(idx));
    // bits above the register are junk and must be dropped
    cfg_pwdata  <= ($urandom & ~keep) | (APB_DATA_W'(value) & keep);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
  endtask

  // wait for the block to go idle, then program all four registers
  task automatic configure(input int lo, input int hi, input int mins,
                           input int need);
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write(REG_LOW_THRESHOLD, lo);
    cfg_write(REG_HIGH_THRESHOLD, hi);
    cfg_write(REG_INTERVAL, mins);
    cfg_write(REG_ALERTS_NEEDED, need);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    lo_aim = lo;
    hi_aim = hi;
  endtask

  // episodes of samples aimed one way, so alert runs build up and break
  task automatic random_phase(input int items, input bit calm);
    int   done;
    int   len;
    aim_t aim;
    done = 0;
    while (done < items) begin
      if (!calm && $urandom_range(0, 3) != 0) begin
        send_gap_pct = $urandom_range(5, 40);
        stall_pct    = $urandom_range(5, 40);
      end else begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      if ($urandom_range(0, 49) == 0) begin
        send_item(KIND_CLEAR, any_temp());
        done++;
      end
      aim = aim_t'($urandom_range(0, 3));
      len = $urandom_range(1, 12);
      repeat (len) begin
        send_item(KIND_SAMPLE, aimed_temp(aim));
        done++;
      end
    end
  endtask

  initial begin : stimulus
    int first_temps [] = '{150, 300, 149, 130, 129, 100, 99, -2048,
                           301, 320, 321, 350, 351, 2047};
    int crossed_temps [] = '{200, 299, 50, 300, 101, 305};
    int a;
    int b;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    send_gap_pct = 20;
    stall_pct    = 20;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset thresholds: band edges, each level on both sides, the extremes,
    // a long alert run past the needed count, then clears with junk payload
    foreach (first_temps[i]) begin
      send_item(KIND_SAMPLE, first_temps[i]);
    end
    send_item(KIND_CLEAR, -1);
    send_item(KIND_SAMPLE, 225);
    send_item(KIND_CLEAR, 0);

    // crossed thresholds, no minutes per sample, zero needed acting as one
    configure(300, 100, 0, 0);
    foreach (crossed_temps[i]) begin
      send_item(KIND_SAMPLE, crossed_temps[i]);
    end

    configure(150, 300, 5, 3);
    random_phase(200, 1'b0);

    // widest band: nothing alerts
    configure(int'(TEMP_MIN), int'(TEMP_MAX), 255, 255);
    random_phase(150, 1'b0);

    // fully crossed: everything alerts
    configure(int'(TEMP_MAX), int'(TEMP_MIN), 0, 0);
    random_phase(150, 1'b0);

    a = int'($urandom_range(0, 1000)) - 500;
    b = int'($urandom_range(0, 1000)) - 500;
    configure(a < b ? a : b, a < b ? b : a, $urandom_range(0, 255),
              $urandom_range(0, 8));
    random_phase(200, 1'b0);

    a = int'($urandom_range(0, 1000)) - 500;
    b = int'($urandom_range(0, 1000)) - 500;
    configure(a < b ? b : a, a < b ? a : b, $urandom_range(0, 255),
              $urandom_range(0, 8));
    random_phase(150, 1'b0);

    // every sample level three at the largest interval: one long alert run,
    // then a normal sample breaks it and a clear wipes the statistics
    configure(0, 100, 255, 0);
    send_gap_pct = 0;
    stall_pct    = 0;
    repeat (ALERT_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        send_item(KIND_SAMPLE, int'($urandom_range(151, 2047)));
      end else begin
        send_item(KIND_SAMPLE, -int'($urandom_range(51, 2048)));
      end
    end
    send_item(KIND_SAMPLE, 50);
    send_item(KIND_CLEAR, any_temp());
    send_item(KIND_SAMPLE, 50);

    // last part runs with no idling on either side
    configure(any_temp(), any_temp(), $urandom_range(0, 255), $urandom_range(0, 255));
    random_phase(300, 1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && reports_owed == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
